// ===== sv/thq_pkg.sv =====
// ----------------------------------------------------------------------------
// thq_pkg
// Shared types, constants and request/result codes of the timer heap queue.
// ----------------------------------------------------------------------------
package thq_pkg;

    localparam int TIMERS    = 16;
    localparam int TIME_BITS = 48;
    localparam int ID_W      = 4;
    localparam int POS_W     = $clog2(TIMERS + 1);
    localparam int PER_W     = 24;
    localparam int TO_W      = 24;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 8;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] RES_ACCEPTED = 2'd0;
    localparam logic [1:0] RES_IGNORED  = 2'd1;
    localparam logic [1:0] RES_EXPIRED  = 2'd2;
    localparam logic [1:0] RES_IDLE     = 2'd3;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [ID_W-1:0]      t_id;

    // One classified command passed from the front to the back.
    typedef struct packed {
        logic [1:0]       req;
        t_id              id;
        logic [TO_W-1:0]  timeout;
        logic [PER_W-1:0] period;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        t_id        id;
        logic       last;
    } t_res;

endpackage

// ===== sv/timer_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// timer_heap_queue_unit
// Binary min-heap timer queue for sixteen timers.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_axis channel (start, stop or tick) and
// results leave on m_axis, one or more beats per request, tlast on the final
// beat. A two-entry command queue sits between the input stage and the heap
// sequencer, so up to two requests are taken while the sequencer is busy.
// Sequencing: the sequencer takes one command at a time and finishes it
// before it takes the next; each heap level of a sift is a read step
// followed by a compare/write step. A tick checks the heap top and, for
// every expired timer, emits a beat and restores the heap.
// Reset clears all timers, the heap count and the time. When m_axis stalls
// the sequencer holds the result and waits; the queue then fills and
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module timer_heap_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[1:0], timer_id[5:2], timeout[29:6], repeat_period[53:30]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_kind[1:0], expired_id[5:2]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    import thq_pkg::*;

    logic w_cv, w_cr;
    t_cmd w_cmd;
    t_res w_res;

    thq_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    thq_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {2'b00, w_res.id, w_res.kind};
    assign m_axis_tlast = w_res.last;

    // a result beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an idle-tick result always closes its run
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.kind == RES_IDLE |-> m_axis_tlast)
        else $error("idle tick without last");

    // the sequencer takes no command while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !w_cr)
        else $error("command taken during output");

endmodule

// ===== sv/thq_front.sv =====
// ----------------------------------------------------------------------------
// thq_front
// Accepts input beats, unpacks them and holds them in a short command queue.
// ----------------------------------------------------------------------------
module thq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [thq_pkg::IN_W-1:0] i_data,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output thq_pkg::t_cmd        o_cmd
);
    import thq_pkg::*;

    t_cmd       r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_in;
    logic       w_push, w_pop;

    // unpack: req[1:0], id[5:2], timeout[29:6], period[53:30]
    assign w_in.req     = i_data[1:0];
    assign w_in.id      = i_data[5:2];
    assign w_in.timeout = i_data[29:6];
    assign w_in.period  = i_data[53:30];

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // store beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== sv/thq_back.sv =====
// ----------------------------------------------------------------------------
// thq_back
// Heap sequencer: carries out start, stop and tick commands on the heap
// memory and emits result beats.
// ----------------------------------------------------------------------------
module thq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  thq_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output thq_pkg::t_res o_res
);
    import thq_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;  // read moved/last entry
    localparam logic [3:0] S_UPRD  = 4'd3;  // read parent
    localparam logic [3:0] S_UPCMP = 4'd4;
    localparam logic [3:0] S_DNRD  = 4'd5;  // read children
    localparam logic [3:0] S_DNCMP = 4'd6;
    localparam logic [3:0] S_PUT   = 4'd7;  // final write
    localparam logic [3:0] S_TOP   = 4'd8;  // check heap top on tick
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_RMPAR = 4'd10; // stop or one-shot expiry: compare with parent

    // heap memory, slots 1..TIMERS
    t_time       r_hd [TIMERS+1];
    t_id         r_hi [TIMERS+1];
    logic [PER_W-1:0] r_per [TIMERS];
    t_pos        r_pos [TIMERS];

    logic [3:0]  r_st;
    t_cmd        r_cmd;
    t_time       r_now;
    t_pos        r_cnt;
    t_pos        r_k;
    t_time       r_d;
    t_id         r_id;
    t_time       r_pd;       // parent or chosen child deadline
    t_id         r_pi;
    t_pos        r_c;
    t_res        r_res;
    logic        r_ov;
    logic [4:0]  r_n;        // expiries emitted this tick
    logic        r_tick;     // result follows further top check
    logic [3:0]  r_after;

    t_pos        w_p, w_c0;
    logic        w_armed;
    t_pos        w_tp;

    assign w_tp    = r_pos[r_cmd.id];
    assign w_armed = (w_tp != '0) && (w_tp <= r_cnt);
    assign w_p     = r_k >> 1;
    assign w_c0    = POS_W'({r_k, 1'b0});

    assign o_cmd_ready = (r_st == S_IDLE);
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_now  <= '0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
            r_n    <= '0;
            for (int i = 0; i < TIMERS; i++) r_pos[i] <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_n   <= '0;
                        r_st  <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_after <= S_OUT;
                    r_tick  <= 1'b0;
                    r_res.id   <= r_cmd.id;
                    r_res.last <= 1'b1;
                    r_res.kind <= RES_IGNORED;
                    r_st       <= S_OUT;
                    if (r_cmd.req == REQ_TICK) begin
                        r_now <= r_now + 1'b1;
                        r_st  <= S_TOP;
                    end else if (r_cmd.req == REQ_START) begin
                        if (!w_armed && r_cnt < POS_W'(TIMERS)) begin
                            r_res.kind        <= RES_ACCEPTED;
                            r_cnt             <= r_cnt + 1'b1;
                            r_k               <= r_cnt + 1'b1;
                            r_per[r_cmd.id]   <= r_cmd.period;
                            r_d  <= r_now + TIME_BITS'(r_cmd.timeout);
                            r_id <= r_cmd.id;
                            r_st <= S_UPRD;
                        end
                    end else if (r_cmd.req == REQ_STOP) begin
                        if (w_armed) begin
                            r_res.kind      <= RES_ACCEPTED;
                            r_pos[r_cmd.id] <= '0;
                            r_cnt           <= r_cnt - 1'b1;
                            r_k             <= w_tp;
                            r_c             <= r_cnt;
                            if (w_tp < r_cnt) r_st <= S_LOAD;
                        end
                    end
                end
                // stop or one-shot expiry: fetch last entry to fill the hole
                S_LOAD: begin
                    r_d  <= r_hd[r_c];
                    r_id <= r_hi[r_c];
                    r_st <= S_RMPAR;
                end
                S_RMPAR: begin
                    r_pd <= r_hd[w_p];
                    if (r_k > 1 && r_d <= r_hd[w_p]) r_st <= S_UPRD;
                    else r_st <= S_DNRD;
                end
                // sift up: per level, read the parent, then compare and move
                S_UPRD: begin
                    if (r_k <= 1) r_st <= S_PUT;
                    else begin
                        r_pd <= r_hd[w_p];
                        r_pi <= r_hi[w_p];
                        r_st <= S_UPCMP;
                    end
                end
                S_UPCMP: begin
                    if (r_pd <= r_d) r_st <= S_PUT;
                    else begin
                        r_hd[r_k]  <= r_pd;
                        r_hi[r_k]  <= r_pi;
                        r_pos[r_pi] <= r_k;
                        r_k  <= w_p;
                        r_st <= S_UPRD;
                    end
                end
                // sift down: pick smaller child
                S_DNRD: begin
                    if (w_c0 > r_cnt || r_k > POS_W'(TIMERS / 2)) r_st <= S_PUT;
                    else begin
                        if (w_c0 + 1'b1 <= r_cnt && r_hd[w_c0] > r_hd[w_c0 + 1'b1]) begin
                            r_c  <= w_c0 + 1'b1;
                            r_pd <= r_hd[w_c0 + 1'b1];
                            r_pi <= r_hi[w_c0 + 1'b1];
                        end else begin
                            r_c  <= w_c0;
                            r_pd <= r_hd[w_c0];
                            r_pi <= r_hi[w_c0];
                        end
                        r_st <= S_DNCMP;
                    end
                end
                S_DNCMP: begin
                    if (r_d <= r_pd) r_st <= S_PUT;
                    else begin
                        r_hd[r_k]   <= r_pd;
                        r_hi[r_k]   <= r_pi;
                        r_pos[r_pi] <= r_k;
                        r_k  <= r_c;
                        r_st <= S_DNRD;
                    end
                end
                S_PUT: begin
                    r_hd[r_k]  <= r_d;
                    r_hi[r_k]  <= r_id;
                    r_pos[r_id] <= r_k;
                    r_st <= r_after;
                end
                // tick: examine heap top
                S_TOP: begin
                    if (r_cnt != '0 && r_hd[1] < r_now && r_n < 5'd16) begin
                        r_res.kind <= RES_EXPIRED;
                        r_res.id   <= r_hi[1];
                        r_res.last <= 1'b0;
                        r_n        <= r_n + 1'b1;
                        r_tick     <= 1'b1;
                        r_after    <= S_OUT;
                        r_k        <= POS_W'(1);
                        if (r_per[r_hi[1]] != '0) begin
                            r_id <= r_hi[1];
                            if (r_hd[1] + TIME_BITS'(r_per[r_hi[1]]) < r_now)
                                r_d <= r_now;
                            else
                                r_d <= r_hd[1] + TIME_BITS'(r_per[r_hi[1]]);
                            r_st <= S_DNRD;
                        end else begin
                            r_pos[r_hi[1]] <= '0;
                            r_cnt <= r_cnt - 1'b1;
                            r_c   <= r_cnt;
                            if (r_cnt > POS_W'(1)) r_st <= S_LOAD;
                            else r_st <= S_OUT;
                        end
                    end else begin
                        // no further expiry: close the run
                        r_tick <= 1'b0;
                        if (r_n == '0) begin
                            r_res.kind <= RES_IDLE;
                            r_res.id   <= '0;
                            r_res.last <= 1'b1;
                            r_ov       <= 1'b1;
                            r_st       <= S_OUT;
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end
                end
                // present a result beat and wait for it to be taken
                S_OUT: begin
                    if (!r_ov) begin
                        if (r_tick) begin
                            r_res.last <= !(r_cnt != '0 && r_hd[1] < r_now
                                            && r_n < 5'd16);
                        end
                        r_ov <= 1'b1;
                    end else if (i_res_ready) begin
                        r_ov <= 1'b0;
                        r_st <= (r_tick && !r_res.last) ? S_TOP : S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule
